@@ design/sed_pkg.sv @@
// Shared types, codes and character helpers for the string escape decoder.
package sed_pkg;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_HEX_HI = 2'd2;
   localparam logic [1:0] MODE_HEX_LO = 2'd3;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_HEX     = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;

   typedef struct packed {
      logic [1:0] escape_mode;
      logic [3:0] high_nibble;
      logic [1:0] sticky_error;
   } state_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic       emit;
      logic [1:0] error_code;
      logic       end_mark;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } escape_type;

   function automatic nibble_type hex_value(input logic [7:0] c);
      nibble_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h41 + 8'd10);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic escape_type simple_escape(input logic [7:0] c);
      escape_type r;
      r.ok = 1'b1;
      case (c)
         8'h27: r.value = 8'h27;   // '
         8'h22: r.value = 8'h22;   // "
         8'h5C: r.value = 8'h5C;   // backslash
         8'h6E: r.value = 8'h0A;   // n
         8'h72: r.value = 8'h0D;   // r
         8'h74: r.value = 8'h09;   // t
         8'h62: r.value = 8'h08;   // b
         8'h66: r.value = 8'h0C;   // f
         8'h76: r.value = 8'h0B;   // v
         8'h30: r.value = 8'h00;   // 0
         8'h61: r.value = 8'h07;   // a
         default: begin
            r.ok    = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

@@ design/sed_if.sv @@
// Valid/ready channel interfaces for the decoder's input and result words.
interface sed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic       final_byte;

   modport source (output valid, output raw_byte, output final_byte, input ready);
   modport sink   (input valid, input raw_byte, input final_byte, output ready);
endinterface

interface sed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] decoded_byte;
   logic       emit;
   logic [1:0] error_code;
   logic       end_mark;

   modport source (output valid, output decoded_byte, output emit, output error_code,
                   output end_mark, input ready);
   modport sink   (input valid, input decoded_byte, input emit, input error_code,
                   input end_mark, output ready);
endinterface

@@ design/sed_step.sv @@
// One decode step: escape state and raw byte in, next state and result out.
module sed_step (
   input  sed_pkg::state_type  state,
   input  logic [7:0]          raw_byte,
   input  logic                final_byte,
   output sed_pkg::state_type  state_next,
   output sed_pkg::result_type result
);
   import sed_pkg::*;

   nibble_type hex;
   escape_type esc;
   state_type  s;
   logic [7:0] out_byte;
   logic       out_emit;

   assign hex = hex_value(raw_byte);
   assign esc = simple_escape(raw_byte);

   always_comb begin
      s        = state;
      out_byte = 8'h00;
      out_emit = 1'b0;
      if (state.sticky_error == ERR_NONE) begin
         unique case (state.escape_mode)
            MODE_PLAIN: begin
               if (raw_byte == CHAR_BACKSLASH) begin
                  s.escape_mode = MODE_ESC;
               end else begin
                  out_byte = raw_byte;
                  out_emit = 1'b1;
               end
            end
            MODE_ESC: begin
               if (raw_byte == CHAR_X) begin
                  s.escape_mode = MODE_HEX_HI;
               end else if (esc.ok) begin
                  out_byte      = esc.value;
                  out_emit      = 1'b1;
                  s.escape_mode = MODE_PLAIN;
               end else begin
                  s.sticky_error = ERR_UNKNOWN;
                  s.escape_mode  = MODE_PLAIN;
               end
            end
            MODE_HEX_HI: begin
               if (hex.ok) begin
                  s.high_nibble = hex.value;
                  s.escape_mode = MODE_HEX_LO;
               end else begin
                  s.sticky_error = ERR_HEX;
                  s.escape_mode  = MODE_PLAIN;
               end
            end
            MODE_HEX_LO: begin
               if (hex.ok) begin
                  out_byte = {state.high_nibble, hex.value};
                  out_emit = 1'b1;
               end else begin
                  s.sticky_error = ERR_HEX;
               end
               s.escape_mode = MODE_PLAIN;
            end
            default: s.escape_mode = MODE_PLAIN;
         endcase
         // literal cut off inside an escape
         if (final_byte && s.sticky_error == ERR_NONE) begin
            if (s.escape_mode == MODE_ESC) begin
               s.sticky_error = ERR_UNKNOWN;
            end else if (s.escape_mode != MODE_PLAIN) begin
               s.sticky_error = ERR_HEX;
            end
         end
      end
      result.decoded_byte = out_byte;
      result.emit         = out_emit;
      result.error_code   = s.sticky_error;
      result.end_mark     = final_byte;
      if (final_byte) begin
         state_next = '0;
      end else begin
         state_next = s;
      end
   end

endmodule

@@ design/string_escape_decoder.sv @@
// Top level of the string escape decoder: input register, decode step, result register.
// Decodes the source text of a C-style string literal, one raw byte per input word,
// into the bytes it stands for; every input word yields exactly one result word, which
// carries the decoded byte (valid when emit is set), the sticky error code and a copy of
// the end mark. A new word is accepted every cycle unless a stalled result word blocks it;
// a word passes from the input register through the decode step into the result register,
// and the escape state advances as a word moves between the two registers.
// The end mark returns the escape state and error to their reset values.
module string_escape_decoder (
   input  logic             clock,
   input  logic             reset,
   sed_req_if.sink          req,
   sed_rsp_if.source        rsp
);
   import sed_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_final_ff, in_final_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff, out_result_in;
   state_type  state_ff, state_in;
   state_type  step_state;
   result_type step_result;
   logic       advance;
   logic       out_free;

   sed_step u_step (
      .state      (state_ff),
      .raw_byte   (in_byte_ff),
      .final_byte (in_final_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_final_in   = in_final_ff;
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      state_in      = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.raw_byte;
         in_final_in = req.final_byte;
      end
      if (out_free) begin
         out_valid_in = advance;
      end
      if (advance) begin
         out_result_in = step_result;
         state_in      = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff    <= in_byte_in;
      in_final_ff   <= in_final_in;
      out_result_ff <= out_result_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.decoded_byte = out_result_ff.decoded_byte;
   assign rsp.emit         = out_result_ff.emit;
   assign rsp.error_code   = out_result_ff.error_code;
   assign rsp.end_mark     = out_result_ff.end_mark;

endmodule

@@ design/sed_checker.sv @@
// Port-level checks for the string escape decoder, bound to the top level.
module sed_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_decoded_byte,
   input logic       rsp_emit,
   input logic [1:0] rsp_error_code,
   input logic       rsp_end_mark
);
   import sed_pkg::*;

   // a decoded byte never comes out while an error stands
   a_emit_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_emit |-> rsp_error_code == ERR_NONE)
      else $error("decoded byte emitted with error set");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_emit |-> rsp_decoded_byte == 8'h00)
      else $error("nonzero byte without emit");

   a_error_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code == ERR_NONE || rsp_error_code == ERR_HEX ||
                    rsp_error_code == ERR_UNKNOWN)
      else $error("error code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decoded_byte) &&
                                 $stable(rsp_emit) && $stable(rsp_error_code) &&
                                 $stable(rsp_end_mark))
      else $error("stalled result word changed");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_decoded_byte (rsp.decoded_byte),
   .rsp_emit         (rsp.emit),
   .rsp_error_code   (rsp.error_code),
   .rsp_end_mark     (rsp.end_mark)
);
